[sv/srtf_pkg.sv]
// shared types and constants for the srtf scheduler
`default_nettype none

package srtf_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam int ARR_W   = 16;
  localparam int BUR_W   = 12;
  localparam int ROW_W   = ARR_W + 2 * BUR_W;
  localparam int CLK_W   = 20;
  localparam int TOT_W   = 24;
  localparam int DONE_W  = 5;
  localparam int PCNT_W  = 5;
  localparam int SLOT_W_PORT = 4;

  localparam logic [PCNT_W-1:0] PCNT_RESET = 5'd16;
  localparam logic [TOT_W-1:0]  CLOCK_MAX  = 24'h0F_FFFF;
  localparam logic [TOT_W-1:0]  TOTAL_MAX  = 24'hFF_FFFF;
  localparam logic [DONE_W-1:0] DONE_MAX   = 5'd31;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_CLOCK,
    ST_TURN,
    ST_WAIT,
    ST_WSUM,
    ST_TSUM,
    ST_RESULT
  } state_t;

  typedef enum logic {
    ALU_SAT_ADD,
    ALU_SUB_CLAMP
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [TOT_W-1:0]  a;
    logic [TOT_W-1:0]  b;
    logic [TOT_W-1:0]  lim;
  } alu_req_t;

endpackage

`default_nettype wire

[sv/srtf_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/srtf_alu.sv]
// shared saturating add / clamped subtract unit
`default_nettype none

module srtf_alu import srtf_pkg::*; (
  input  wire alu_req_t         req,
  output logic [TOT_W-1:0]      res
);

  logic [TOT_W:0] sum;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, req.b};
    case (req.op)
      ALU_SAT_ADD: begin
        res = (sum > {1'b0, req.lim}) ? req.lim : sum[TOT_W-1:0];
      end
      ALU_SUB_CLAMP: begin
        res = (req.a > req.b) ? (req.a - req.b) : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/srtf_preemptive_scheduler.sv]
// srtf scheduler top: slot table, scan sequencer and result register
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | kind, slot, arrival_time, burst_time
//   out_    | output    | out_valid / out_ready  | chosen_slot .. turnaround_sum
//   cfg_    | input     | cfg_wr_en (no wait)    | cfg_wr_data = process_count
//
// a load and a tick each scan the slots in use before their result:
// the slot table has one read port, so the minimum search reads one row per cycle.
// the finish, wait and total arithmetic runs one step a cycle on one shared unit.
// reset (synchronous, rst_n low) clears the row valid bits, clock and totals.
// in_ready is low while an item is in work; a result waits in the output register
// and the next item is taken while it waits.
`default_nettype none

module srtf_preemptive_scheduler import srtf_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_kind,
  input  wire logic [3:0]             in_slot,
  input  wire logic [15:0]            in_arrival_time,
  input  wire logic [11:0]            in_burst_time,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [3:0]             out_chosen_slot,
  output logic                        out_idle,
  output logic                        out_finished,
  output logic                        out_all_done,
  output logic      [19:0]            out_finish_time,
  output logic      [19:0]            out_wait_time,
  output logic      [19:0]            out_turnaround_time,
  output logic      [23:0]            out_wait_sum,
  output logic      [23:0]            out_turnaround_sum,
  input  wire logic                   cfg_wr_en,
  input  wire logic [4:0]             cfg_wr_data
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

  state_t state_r, state_nxt;

  // configuration and run state
  logic [PCNT_W-1:0]     pcount_r;
  logic [CLK_W-1:0]      clock_r;
  logic [DONE_W-1:0]     done_r;
  logic [TOT_W-1:0]      wait_tot_r;
  logic [TOT_W-1:0]      turn_tot_r;
  logic [SLOT_COUNT-1:0] valid_r;

  // captured transaction
  logic                  item_kind_r;
  logic [3:0]            item_slot_r;
  logic [ARR_W-1:0]      item_arr_r;
  logic [BUR_W-1:0]      item_bur_r;

  // scan state
  logic [CNT_W-1:0]      scan_idx_r;
  logic [SLOT_W-1:0]     rd_addr_r;
  logic                  rd_valid_r;
  logic                  found_r;
  logic [1:0]            nz_r;
  logic [SLOT_W-1:0]     best_idx_r;
  logic [BUR_W-1:0]      best_rem_r;
  logic [ARR_W-1:0]      best_arr_r;
  logic [BUR_W-1:0]      best_bur_r;

  // finish arithmetic
  logic [CLK_W-1:0]      ft_r;
  logic [CLK_W-1:0]      tt_r;
  logic [CLK_W-1:0]      wt_r;

  // result register
  logic                  out_valid_r;
  logic [3:0]            o_chosen_r;
  logic                  o_idle_r;
  logic                  o_fin_r;
  logic                  o_all_done_r;
  logic [CLK_W-1:0]      o_ft_r;
  logic [CLK_W-1:0]      o_wt_r;
  logic [CLK_W-1:0]      o_tt_r;
  logic [TOT_W-1:0]      o_wsum_r;
  logic [TOT_W-1:0]      o_tsum_r;

  // ram and alu hookup
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;
  alu_req_t              alu_req;
  logic [TOT_W-1:0]      alu_res;

  logic [CNT_W-1:0]      n_use;
  logic                  in_range;
  logic [SLOT_W-1:0]     ld_addr;
  logic [ARR_W-1:0]      row_arr;
  logic [BUR_W-1:0]      row_bur;
  logic [BUR_W-1:0]      row_rem;
  logic                  elig;
  logic                  pick;
  logic                  scan_last;
  logic                  will_finish;
  logic                  in_fire;
  logic                  res_load;

  srtf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srtf_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // slots in use, clamped to 1..SLOT_COUNT
  always_comb begin
    if (pcount_r == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(pcount_r) > SLOT_COUNT) begin
      n_use = CNT_W'(SLOT_COUNT);
    end else begin
      n_use = CNT_W'(pcount_r);
    end
  end

  assign in_range  = 32'(item_slot_r) < SLOT_COUNT;
  assign ld_addr   = SLOT_W'(item_slot_r);
  assign in_fire   = in_valid && in_ready;

  // rows never loaded read as zero
  assign row_arr = rd_valid_r ? ram_rdata[ROW_W-1 -: ARR_W] : '0;
  assign row_bur = rd_valid_r ? ram_rdata[2*BUR_W-1 -: BUR_W] : '0;
  assign row_rem = rd_valid_r ? ram_rdata[BUR_W-1:0] : '0;

  assign elig        = (CLK_W'(row_arr) <= clock_r) && (row_rem != '0);
  assign pick        = elig && (!found_r || (row_rem < best_rem_r));
  assign scan_last   = (scan_idx_r == n_use);
  assign will_finish = found_r && (best_rem_r == BUR_W'(1));
  assign res_load    = (state_r == ST_RESULT) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_kind == KIND_TICK) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = (item_kind_r == KIND_TICK) ? ST_CLOCK : ST_RESULT;
        end
      end
      ST_CLOCK: begin
        state_nxt = will_finish ? ST_TURN : ST_RESULT;
      end
      ST_TURN: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_WSUM;
      end
      ST_WSUM: begin
        state_nxt = ST_TSUM;
      end
      ST_TSUM: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = ld_addr;
    ram_wdata    = {item_arr_r, item_bur_r, item_bur_r};
    ram_raddr    = scan_idx_r[SLOT_W-1:0];
    alu_req.op   = ALU_SAT_ADD;
    alu_req.a    = '0;
    alu_req.b    = '0;
    alu_req.lim  = TOTAL_MAX;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOAD: begin
        ram_we = in_range;
      end
      ST_CLOCK: begin
        ram_we      = found_r;
        ram_waddr   = best_idx_r;
        ram_wdata   = {best_arr_r, best_bur_r, best_rem_r - BUR_W'(1)};
        alu_req.a   = TOT_W'(clock_r);
        alu_req.b   = TOT_W'(1);
        alu_req.lim = CLOCK_MAX;
      end
      ST_TURN: begin
        alu_req.op = ALU_SUB_CLAMP;
        alu_req.a  = TOT_W'(ft_r);
        alu_req.b  = TOT_W'(best_arr_r);
      end
      ST_WAIT: begin
        alu_req.op = ALU_SUB_CLAMP;
        alu_req.a  = TOT_W'(tt_r);
        alu_req.b  = TOT_W'(best_bur_r);
      end
      ST_WSUM: begin
        alu_req.a = wait_tot_r;
        alu_req.b = TOT_W'(wt_r);
      end
      ST_TSUM: begin
        alu_req.a = turn_tot_r;
        alu_req.b = TOT_W'(tt_r);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcount_r    <= PCNT_RESET;
      clock_r     <= '0;
      done_r      <= '0;
      wait_tot_r  <= '0;
      turn_tot_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        pcount_r <= cfg_wr_data;
      end
      if (state_r == ST_LOAD && in_range) begin
        valid_r[ld_addr] <= 1'b1;
        clock_r          <= '0;
        done_r           <= '0;
        wait_tot_r       <= '0;
        turn_tot_r       <= '0;
      end
      if (state_r == ST_CLOCK) begin
        clock_r <= alu_res[CLK_W-1:0];
        if (will_finish && done_r != DONE_MAX) begin
          done_r <= done_r + DONE_W'(1);
        end
      end
      if (state_r == ST_WSUM) begin
        wait_tot_r <= alu_res;
      end
      if (state_r == ST_TSUM) begin
        turn_tot_r <= alu_res;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_addr_r  <= ram_raddr;
    rd_valid_r <= valid_r[ram_raddr];
    if (in_fire) begin
      item_kind_r <= in_kind;
      item_slot_r <= in_slot;
      item_arr_r  <= in_arrival_time;
      item_bur_r  <= in_burst_time;
      scan_idx_r  <= '0;
      found_r     <= 1'b0;
      nz_r        <= '0;
      best_idx_r  <= '0;
      best_rem_r  <= '0;
      best_arr_r  <= '0;
      best_bur_r  <= '0;
    end
    if (state_r == ST_SCAN) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
      // compare stage works on the row whose read was issued in the previous scan step
      if (scan_idx_r != '0) begin
        if (row_rem != '0 && nz_r != 2'd2) begin
          nz_r <= nz_r + 2'd1;
        end
        if (pick) begin
          found_r    <= 1'b1;
          best_idx_r <= rd_addr_r;
          best_rem_r <= row_rem;
          best_arr_r <= row_arr;
          best_bur_r <= row_bur;
        end
      end
    end
    if (state_r == ST_CLOCK) begin
      ft_r <= alu_res[CLK_W-1:0];
    end
    if (state_r == ST_TURN) begin
      tt_r <= alu_res[CLK_W-1:0];
    end
    if (state_r == ST_WAIT) begin
      wt_r <= alu_res[CLK_W-1:0];
    end
    if (res_load) begin
      if (item_kind_r == KIND_TICK) begin
        o_chosen_r   <= found_r ? 4'(best_idx_r) : 4'd0;
        o_idle_r     <= !found_r;
        o_fin_r      <= will_finish;
        o_all_done_r <= (nz_r == 2'd0) || (nz_r == 2'd1 && will_finish);
        o_ft_r       <= will_finish ? ft_r : '0;
        o_wt_r       <= will_finish ? wt_r : '0;
        o_tt_r       <= will_finish ? tt_r : '0;
      end else begin
        o_chosen_r   <= 4'd0;
        o_idle_r     <= 1'b0;
        o_fin_r      <= 1'b0;
        o_all_done_r <= (nz_r == 2'd0);
        o_ft_r       <= '0;
        o_wt_r       <= '0;
        o_tt_r       <= '0;
      end
      o_wsum_r <= wait_tot_r;
      o_tsum_r <= turn_tot_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chosen_slot     = o_chosen_r;
  assign out_idle            = o_idle_r;
  assign out_finished        = o_fin_r;
  assign out_all_done        = o_all_done_r;
  assign out_finish_time     = o_ft_r;
  assign out_wait_time       = o_wt_r;
  assign out_turnaround_time = o_tt_r;
  assign out_wait_sum        = o_wsum_r;
  assign out_turnaround_sum  = o_tsum_r;

endmodule

`default_nettype wire
